### rtl/core/sfc_pkg.sv
// sfc_pkg: shared types, constants and crc tables for the safety frame crc block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;

  localparam int DATA_WORDS = 5;
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_WORDS - 1);
  localparam logic [16:0] MAX_TRIES = 17'h10000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EVAL,
    ST_OUT
  } sfc_state_t;

  typedef struct packed {
    logic       func;
    logic [2:0] word_index;
    logic [7:0] command;
    logic [15:0] conn_id;
    logic [15:0] sequence_in;
    logic [15:0] chained_crc;
    logic [15:0] previous_own_crc;
    logic [15:0] data_word;
    logic [15:0] expected_crc;
  } sfc_in_t;

  typedef struct packed {
    logic [15:0] crc_word;
    logic        crc_match;
    logic        frame_ok;
    logic [15:0] sequence_out;
    logic        last_word;
  } sfc_out_t;

  localparam logic [15:0] TAB_HI [256] = '{
    16'h0000,16'h39B7,16'h736E,16'h4AD9,16'hE6DC,16'hDF6B,16'h95B2,16'hAC05,
    16'hF40F,16'hCDB8,16'h8761,16'hBED6,16'h12D3,16'h2B64,16'h61BD,16'h580A,
    16'hD1A9,16'hE81E,16'hA2C7,16'h9B70,16'h3775,16'h0EC2,16'h441B,16'h7DAC,
    16'h25A6,16'h1C11,16'h56C8,16'h6F7F,16'hC37A,16'hFACD,16'hB014,16'h89A3,
    16'h9AE5,16'hA352,16'hE98B,16'hD03C,16'h7C39,16'h458E,16'h0F57,16'h36E0,
    16'h6EEA,16'h575D,16'h1D84,16'h2433,16'h8836,16'hB181,16'hFB58,16'hC2EF,
    16'h4B4C,16'h72FB,16'h3822,16'h0195,16'hAD90,16'h9427,16'hDEFE,16'hE749,
    16'hBF43,16'h86F4,16'hCC2D,16'hF59A,16'h599F,16'h6028,16'h2AF1,16'h1346,
    16'h0C7D,16'h35CA,16'h7F13,16'h46A4,16'hEAA1,16'hD316,16'h99CF,16'hA078,
    16'hF872,16'hC1C5,16'h8B1C,16'hB2AB,16'h1EAE,16'h2719,16'h6DC0,16'h5477,
    16'hDDD4,16'hE463,16'hAEBA,16'h970D,16'h3B08,16'h02BF,16'h4866,16'h71D1,
    16'h29DB,16'h106C,16'h5AB5,16'h6302,16'hCF07,16'hF6B0,16'hBC69,16'h85DE,
    16'h9698,16'hAF2F,16'hE5F6,16'hDC41,16'h7044,16'h49F3,16'h032A,16'h3A9D,
    16'h6297,16'h5B20,16'h11F9,16'h284E,16'h844B,16'hBDFC,16'hF725,16'hCE92,
    16'h4731,16'h7E86,16'h345F,16'h0DE8,16'hA1ED,16'h985A,16'hD283,16'hEB34,
    16'hB33E,16'h8A89,16'hC050,16'hF9E7,16'h55E2,16'h6C55,16'h268C,16'h1F3B,
    16'h18FA,16'h214D,16'h6B94,16'h5223,16'hFE26,16'hC791,16'h8D48,16'hB4FF,
    16'hECF5,16'hD542,16'h9F9B,16'hA62C,16'h0A29,16'h339E,16'h7947,16'h40F0,
    16'hC953,16'hF0E4,16'hBA3D,16'h838A,16'h2F8F,16'h1638,16'h5CE1,16'h6556,
    16'h3D5C,16'h04EB,16'h4E32,16'h7785,16'hDB80,16'hE237,16'hA8EE,16'h9159,
    16'h821F,16'hBBA8,16'hF171,16'hC8C6,16'h64C3,16'h5D74,16'h17AD,16'h2E1A,
    16'h7610,16'h4FA7,16'h057E,16'h3CC9,16'h90CC,16'hA97B,16'hE3A2,16'hDA15,
    16'h53B6,16'h6A01,16'h20D8,16'h196F,16'hB56A,16'h8CDD,16'hC604,16'hFFB3,
    16'hA7B9,16'h9E0E,16'hD4D7,16'hED60,16'h4165,16'h78D2,16'h320B,16'h0BBC,
    16'h1487,16'h2D30,16'h67E9,16'h5E5E,16'hF25B,16'hCBEC,16'h8135,16'hB882,
    16'hE088,16'hD93F,16'h93E6,16'hAA51,16'h0654,16'h3FE3,16'h753A,16'h4C8D,
    16'hC52E,16'hFC99,16'hB640,16'h8FF7,16'h23F2,16'h1A45,16'h509C,16'h692B,
    16'h3121,16'h0896,16'h424F,16'h7BF8,16'hD7FD,16'hEE4A,16'hA493,16'h9D24,
    16'h8E62,16'hB7D5,16'hFD0C,16'hC4BB,16'h68BE,16'h5109,16'h1BD0,16'h2267,
    16'h7A6D,16'h43DA,16'h0903,16'h30B4,16'h9CB1,16'hA506,16'hEFDF,16'hD668,
    16'h5FCB,16'h667C,16'h2CA5,16'h1512,16'hB917,16'h80A0,16'hCA79,16'hF3CE,
    16'hABC4,16'h9273,16'hD8AA,16'hE11D,16'h4D18,16'h74AF,16'h3E76,16'h07C1
  };

  localparam logic [15:0] TAB_DAT [256] = '{
    16'h0000,16'h7648,16'hEC90,16'h9AD8,16'hE097,16'h96DF,16'h0C07,16'h7A4F,
    16'hF899,16'h8ED1,16'h1409,16'h6241,16'h180E,16'h6E46,16'hF49E,16'h82D6,
    16'hC885,16'hBECD,16'h2415,16'h525D,16'h2812,16'h5E5A,16'hC482,16'hB2CA,
    16'h301C,16'h4654,16'hDC8C,16'hAAC4,16'hD08B,16'hA6C3,16'h3C1B,16'h4A53,
    16'hA8BD,16'hDEF5,16'h442D,16'h3265,16'h482A,16'h3E62,16'hA4BA,16'hD2F2,
    16'h5024,16'h266C,16'hBCB4,16'hCAFC,16'hB0B3,16'hC6FB,16'h5C23,16'h2A6B,
    16'h6038,16'h1670,16'h8CA8,16'hFAE0,16'h80AF,16'hF6E7,16'h6C3F,16'h1A77,
    16'h98A1,16'hEEE9,16'h7431,16'h0279,16'h7836,16'h0E7E,16'h94A6,16'hE2EE,
    16'h68CD,16'h1E85,16'h845D,16'hF215,16'h885A,16'hFE12,16'h64CA,16'h1282,
    16'h9054,16'hE61C,16'h7CC4,16'h0A8C,16'h70C3,16'h068B,16'h9C53,16'hEA1B,
    16'hA048,16'hD600,16'h4CD8,16'h3A90,16'h40DF,16'h3697,16'hAC4F,16'hDA07,
    16'h58D1,16'h2E99,16'hB441,16'hC209,16'hB846,16'hCE0E,16'h54D6,16'h229E,
    16'hC070,16'hB638,16'h2CE0,16'h5AA8,16'h20E7,16'h56AF,16'hCC77,16'hBA3F,
    16'h38E9,16'h4EA1,16'hD479,16'hA231,16'hD87E,16'hAE36,16'h34EE,16'h42A6,
    16'h08F5,16'h7EBD,16'hE465,16'h922D,16'hE862,16'h9E2A,16'h04F2,16'h72BA,
    16'hF06C,16'h8624,16'h1CFC,16'h6AB4,16'h10FB,16'h66B3,16'hFC6B,16'h8A23,
    16'hD19A,16'hA7D2,16'h3D0A,16'h4B42,16'h310D,16'h4745,16'hDD9D,16'hABD5,
    16'h2903,16'h5F4B,16'hC593,16'hB3DB,16'hC994,16'hBFDC,16'h2504,16'h534C,
    16'h191F,16'h6F57,16'hF58F,16'h83C7,16'hF988,16'h8FC0,16'h1518,16'h6350,
    16'hE186,16'h97CE,16'h0D16,16'h7B5E,16'h0111,16'h7759,16'hED81,16'h9BC9,
    16'h7927,16'h0F6F,16'h95B7,16'hE3FF,16'h99B0,16'hEFF8,16'h7520,16'h0368,
    16'h81BE,16'hF7F6,16'h6D2E,16'h1B66,16'h6129,16'h1761,16'h8DB9,16'hFBF1,
    16'hB1A2,16'hC7EA,16'h5D32,16'h2B7A,16'h5135,16'h277D,16'hBDA5,16'hCBED,
    16'h493B,16'h3F73,16'hA5AB,16'hD3E3,16'hA9AC,16'hDFE4,16'h453C,16'h3374,
    16'hB957,16'hCF1F,16'h55C7,16'h238F,16'h59C0,16'h2F88,16'hB550,16'hC318,
    16'h41CE,16'h3786,16'hAD5E,16'hDB16,16'hA159,16'hD711,16'h4DC9,16'h3B81,
    16'h71D2,16'h079A,16'h9D42,16'hEB0A,16'h9145,16'hE70D,16'h7DD5,16'h0B9D,
    16'h894B,16'hFF03,16'h65DB,16'h1393,16'h69DC,16'h1F94,16'h854C,16'hF304,
    16'h11EA,16'h67A2,16'hFD7A,16'h8B32,16'hF17D,16'h8735,16'h1DED,16'h6BA5,
    16'hE973,16'h9F3B,16'h05E3,16'h73AB,16'h09E4,16'h7FAC,16'hE574,16'h933C,
    16'hD96F,16'hAF27,16'h35FF,16'h43B7,16'h39F8,16'h4FB0,16'hD568,16'hA320,
    16'h21F6,16'h57BE,16'hCD66,16'hBB2E,16'hC161,16'hB729,16'h2DF1,16'h5BB9
  };

endpackage
`default_nettype wire

### rtl/core/sfc_if.sv
// sfc_if: valid/ready channel carrying one payload struct
// depends on sfc_pkg
`timescale 1ns / 1ps
`default_nettype none
interface sfc_in_if;
  import sfc_pkg::*;
  logic    valid;
  logic    ready;
  sfc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfc_out_if;
  import sfc_pkg::*;
  logic     valid;
  logic     ready;
  sfc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/sfc_byte_unit.sv
// sfc_byte_unit: one two-table crc byte update, shared by every step
// depends on sfc_pkg tables
`timescale 1ns / 1ps
`default_nettype none
module sfc_byte_unit (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic [15:0]      crc_o
);
  import sfc_pkg::*;
  logic [15:0] t;
  always_comb begin
    t = TAB_HI[crc_i[15:8]] ^ TAB_DAT[byte_i];
    crc_o = {t[15:8] ^ crc_i[7:0], t[7:0]};
  end
endmodule
`default_nettype wire

### rtl/core/safety_frame_crc.sv
// safety_frame_crc: per-word crc generator and checker for a safety frame
// one byte update per cycle in the run state; word 0 hashes the header and data word
// on each header try, later words hash index and data word; each collision adds one try
// one transaction at a time; result held in an output register until taken
// synchronous active-low reset clears control, header crc and used sequence, sets frame status good
`timescale 1ns / 1ps
`default_nettype none
module safety_frame_crc (
  input  wire logic clk,
  input  wire logic rst_n,
  sfc_in_if.sink    in_ch,
  sfc_out_if.source out_ch
);
  import sfc_pkg::*;

  sfc_state_t  state_r, state_nxt;
  sfc_in_t     item_r;
  logic [3:0]  step_r;
  logic [15:0] crc_r, seq_r, hdr_r, seq_used_r;
  logic        good_r;
  logic [16:0] tries_r;
  sfc_out_t    res_r;
  logic [7:0]  byte_sel;
  logic [15:0] crc_new;
  logic [3:0]  last_step;
  logic        is_hdr, collide, in_frame, match;

  assign is_hdr    = (item_r.word_index == '0);
  assign last_step = is_hdr ? 4'd8 : 4'd3;
  assign collide   = (crc_r == item_r.previous_own_crc) && (tries_r != MAX_TRIES - 17'd1);
  assign in_frame  = (32'(item_r.word_index) < DATA_WORDS);
  assign match     = item_r.func ? (crc_r == item_r.expected_crc) : 1'b1;

  always_comb begin
    byte_sel = '0;
    if (is_hdr) begin
      unique case (step_r)
        4'd0: byte_sel = item_r.chained_crc[7:0];
        4'd1: byte_sel = item_r.chained_crc[15:8];
        4'd2: byte_sel = item_r.conn_id[7:0];
        4'd3: byte_sel = item_r.conn_id[15:8];
        4'd4: byte_sel = seq_r[7:0];
        4'd5: byte_sel = seq_r[15:8];
        4'd6: byte_sel = item_r.command;
        4'd7: byte_sel = item_r.data_word[7:0];
        4'd8: byte_sel = item_r.data_word[15:8];
        default: byte_sel = '0;
      endcase
    end else begin
      unique case (step_r)
        4'd0: byte_sel = {5'd0, item_r.word_index};
        4'd1: byte_sel = 8'd0;
        4'd2: byte_sel = item_r.data_word[7:0];
        4'd3: byte_sel = item_r.data_word[15:8];
        default: byte_sel = '0;
      endcase
    end
  end

  sfc_byte_unit u_byte (.crc_i(crc_r), .byte_i(byte_sel), .crc_o(crc_new));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_RUN;
      ST_RUN:  if (step_r == last_step) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = (is_hdr && collide) ? ST_RUN : ST_OUT;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_OUT);
    out_ch.data  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      hdr_r      <= '0;
      seq_used_r <= '0;
      good_r     <= 1'b1;
      step_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          item_r  <= in_ch.data;
          seq_r   <= in_ch.data.sequence_in;
          crc_r   <= (in_ch.data.word_index == '0) ? 16'd0 : hdr_r;
          step_r  <= '0;
          tries_r <= '0;
        end
        ST_RUN: begin
          crc_r  <= crc_new;
          step_r <= step_r + 4'd1;
          if (is_hdr && step_r == 4'd6) hdr_r <= crc_new;
        end
        ST_EVAL: begin
          step_r <= '0;
          if (is_hdr && collide) begin
            crc_r   <= '0;
            tries_r <= tries_r + 17'd1;
            seq_r   <= (seq_r == 16'hFFFF) ? 16'd1 : seq_r + 16'd1;
          end else begin
            res_r.crc_word  <= crc_r;
            res_r.crc_match <= match;
            res_r.last_word <= (item_r.word_index == LAST_IDX);
            if (is_hdr) begin
              seq_used_r         <= seq_r;
              res_r.sequence_out <= seq_r;
              good_r             <= match;
              res_r.frame_ok     <= match;
            end else begin
              res_r.sequence_out <= seq_used_r;
              good_r             <= in_frame ? (good_r & match) : good_r;
              res_r.frame_ok     <= in_frame ? (good_r & match) : good_r;
            end
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/sfc_checker.sv
// sfc_checker: port-level assertions for safety_frame_crc, bound to the top level
// depends on sfc_pkg and the channel interfaces
`timescale 1ns / 1ps
`default_nettype none
module sfc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_crc_match,
  input wire logic out_frame_ok,
  input wire logic [15:0] out_crc_word
);
  import sfc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_crc_word))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready while result pending");
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_crc_match) && $stable(out_frame_ok))
    else $error("frame status changed while stalled");
endmodule

bind safety_frame_crc sfc_checker u_sfc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_crc_match(out_ch.data.crc_match), .out_frame_ok(out_ch.data.frame_ok),
  .out_crc_word(out_ch.data.crc_word)
);
`default_nettype wire
